// ----- src/llsf_pkg.sv -----
// Shared constants and types of the least-squares fit core.
`timescale 1ns / 1ps
package llsf_pkg;

    localparam int CNT_W      = 16;
    localparam int FIELD_W    = 48;
    localparam int RSQ_W      = 17;
    localparam int QBITS      = 50;
    localparam int FRAC_SHIFT = 17;
    localparam int QSH        = QBITS - FRAC_SHIFT;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_XFLAT = 2'd1;
    localparam t_status ST_YFLAT = 2'd2;

    localparam logic [QBITS-1:0] POS_MAX = QBITS'(48'h7FFF_FFFF_FFFF);
    localparam logic [QBITS-1:0] NEG_MAX = QBITS'(48'h8000_0000_0000);
    localparam logic [QBITS-1:0] RSQ_MAX = QBITS'(17'h10000);

endpackage

// ----- src/llsf_accum.sv -----
// Front part: accepts sample items and keeps the running sums.
`timescale 1ns / 1ps
module llsf_accum #(
    parameter int MAX_SAMPLES = 65535,
    parameter int SAMPLE_BITS = 16,
    parameter int SW          = SAMPLE_BITS + 17,
    parameter int PW          = 2 * SAMPLE_BITS + 16,
    parameter int SNAP_W      = 16 + 2 * SW + 3 * PW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_x_value,
    input  logic signed [SAMPLE_BITS-1:0] i_y_value,
    input  logic                          i_last_sample,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output logic [SNAP_W-1:0]             o_push_data
);
    import llsf_pkg::*;

    localparam int S = SAMPLE_BITS;

    logic [CNT_W-1:0]     r_n, n_n;
    logic signed [SW-1:0] r_sx, n_sx, r_sy, n_sy, xe, ye;
    logic signed [PW-1:0] r_sxy, n_sxy, r_sxx, n_sxx, r_syy, n_syy;
    logic signed [2*S-1:0] pxy, pxx, pyy;
    logic keep, accept;

    assign pxy = i_x_value * i_y_value;
    assign pxx = i_x_value * i_x_value;
    assign pyy = i_y_value * i_y_value;
    assign xe  = {{(SW-S){i_x_value[S-1]}}, i_x_value};
    assign ye  = {{(SW-S){i_y_value[S-1]}}, i_y_value};

    assign keep   = r_n < CNT_W'(MAX_SAMPLES);
    assign accept = i_valid & i_push_ready;
    assign o_ready = i_push_ready;

    always_comb begin
        n_n   = r_n;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxy = r_sxy;
        n_sxx = r_sxx;
        n_syy = r_syy;
        if (keep) begin
            n_n   = r_n + CNT_W'(1);
            n_sx  = r_sx + xe;
            n_sy  = r_sy + ye;
            n_sxy = r_sxy + {{(PW-2*S){pxy[2*S-1]}}, pxy};
            n_sxx = r_sxx + {{(PW-2*S){pxx[2*S-1]}}, pxx};
            n_syy = r_syy + {{(PW-2*S){pyy[2*S-1]}}, pyy};
        end
    end

    assign o_push_valid = accept & i_last_sample;
    assign o_push_data  = {n_n, n_sx, n_sy, n_sxy, n_sxx, n_syy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_sample)) begin
            r_n   <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
            r_syy <= '0;
        end else if (accept) begin
            r_n   <= n_n;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sxy <= n_sxy;
            r_sxx <= n_sxx;
            r_syy <= n_syy;
        end
    end

endmodule

// ----- src/llsf_fifo.sv -----
// Two-entry queue between the front and the solver.
`timescale 1ns / 1ps
module llsf_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_can_push,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_can_push = r_cnt != 2'd2;
    assign o_valid    = r_cnt != 2'd0;
    assign o_data     = r_mem[r_rd];
    assign do_push    = i_push & o_can_push;
    assign do_pop     = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ----- src/llsf_solver.sv -----
// Back part: closed-form fit with a shift-add multiplier and a restoring divider.
`timescale 1ns / 1ps
module llsf_solver #(
    parameter int SAMPLE_BITS = 16,
    parameter int SW          = SAMPLE_BITS + 17,
    parameter int PW          = 2 * SAMPLE_BITS + 16,
    parameter int SNAP_W      = 16 + 2 * SW + 3 * PW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_pop,
    input  logic [SNAP_W-1:0]             i_job_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [llsf_pkg::FIELD_W-1:0]  o_slope,
    output logic [llsf_pkg::FIELD_W-1:0]  o_intercept,
    output logic [llsf_pkg::RSQ_W-1:0]    o_r_squared,
    output logic [llsf_pkg::CNT_W-1:0]    o_sample_count,
    output llsf_pkg::t_status             o_fit_status
);
    import llsf_pkg::*;

    localparam int MW  = 2 * SAMPLE_BITS + 35;
    localparam int WW  = 2 * MW;
    localparam int LW  = WW + 1;
    localparam int CTW = $clog2(MW > QBITS ? MW : QBITS);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MUL_LOAD = 3'd1;
    localparam logic [2:0] S_MUL_RUN  = 3'd2;
    localparam logic [2:0] S_MUL_DONE = 3'd3;
    localparam logic [2:0] S_DIV_LOAD = 3'd4;
    localparam logic [2:0] S_DIV_RUN  = 3'd5;
    localparam logic [2:0] S_DIV_DONE = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    localparam logic [3:0] M_N_SXX  = 4'd0;
    localparam logic [3:0] M_SX_SX  = 4'd1;
    localparam logic [3:0] M_N_SYY  = 4'd2;
    localparam logic [3:0] M_SY_SY  = 4'd3;
    localparam logic [3:0] M_N_SXY  = 4'd4;
    localparam logic [3:0] M_SX_SY  = 4'd5;
    localparam logic [3:0] M_SXX_SY = 4'd6;
    localparam logic [3:0] M_SX_SXY = 4'd7;
    localparam logic [3:0] M_C_C    = 4'd8;
    localparam logic [3:0] M_DX_DY  = 4'd9;

    localparam logic [1:0] D_SLOPE = 2'd0;
    localparam logic [1:0] D_ICPT  = 2'd1;
    localparam logic [1:0] D_RSQ   = 2'd2;

    logic [2:0]            r_state;
    logic [3:0]            r_mstep;
    logic [1:0]            r_dstep;
    logic [CTW-1:0]        r_cnt;
    logic [CNT_W-1:0]      r_n;
    logic signed [SW-1:0]  r_sx, r_sy;
    logic signed [PW-1:0]  r_sxy, r_sxx, r_syy;
    logic signed [LW-1:0]  r_t1, r_dx, r_dy, r_c, r_ni;
    logic [WW-1:0]         r_c2, r_d2;
    logic [WW-1:0]         r_ma, r_mp;
    logic [MW-1:0]         r_mb;
    logic                  r_psign;
    logic [WW-1:0]         r_den, r_rem;
    logic [QBITS-1:0]      r_dq;
    logic                  r_ovf, r_qneg;
    logic [FIELD_W-1:0]    r_slope, r_icpt;
    logic [RSQ_W-1:0]      r_rsq;
    t_status               r_status;

    logic signed [LW-1:0]  op_a, op_b, a_mag, b_mag, sprod;
    logic                  a_neg, b_neg, x_flat, y_flat;
    logic [WW-1:0]         d_num, d_den;
    logic                  d_neg;
    logic [WW:0]           rs;
    logic                  ge;
    logic [QBITS-1:0]      q_round, q_max, q_sat;
    logic [FIELD_W-1:0]    q_field;

    always_comb begin
        case (r_mstep)
            M_N_SXX:  begin op_a = LW'(r_n);  op_b = LW'(r_sxx); end
            M_SX_SX:  begin op_a = LW'(r_sx); op_b = LW'(r_sx);  end
            M_N_SYY:  begin op_a = LW'(r_n);  op_b = LW'(r_syy); end
            M_SY_SY:  begin op_a = LW'(r_sy); op_b = LW'(r_sy);  end
            M_N_SXY:  begin op_a = LW'(r_n);  op_b = LW'(r_sxy); end
            M_SX_SY:  begin op_a = LW'(r_sx); op_b = LW'(r_sy);  end
            M_SXX_SY: begin op_a = LW'(r_sxx); op_b = LW'(r_sy); end
            M_SX_SXY: begin op_a = LW'(r_sx); op_b = LW'(r_sxy); end
            M_C_C:    begin op_a = r_c;  op_b = r_c;  end
            M_DX_DY:  begin op_a = r_dx; op_b = r_dy; end
            default:  begin op_a = '0;   op_b = '0;   end
        endcase
    end

    assign a_neg = op_a[LW-1];
    assign b_neg = op_b[LW-1];
    assign a_mag = a_neg ? -op_a : op_a;
    assign b_mag = b_neg ? -op_b : op_b;
    assign sprod = r_psign ? -$signed({1'b0, r_mp}) : $signed({1'b0, r_mp});

    assign x_flat = r_dx[LW-1] || (r_dx == '0);
    assign y_flat = r_dy[LW-1] || (r_dy == '0);

    always_comb begin
        d_den = r_dx[WW-1:0];
        case (r_dstep)
            D_SLOPE: begin
                d_neg = r_c[LW-1];
                d_num = d_neg ? WW'(-r_c) : r_c[WW-1:0];
            end
            D_ICPT: begin
                d_neg = r_ni[LW-1];
                d_num = d_neg ? WW'(-r_ni) : r_ni[WW-1:0];
            end
            default: begin
                d_neg = 1'b0;
                d_num = r_c2;
                d_den = r_d2;
            end
        endcase
    end

    assign rs = {r_rem, r_dq[QBITS-1]};
    assign ge = rs >= {1'b0, r_den};

    assign q_round = {1'b0, r_dq[QBITS-1:1]} + QBITS'(r_dq[0]);
    assign q_max   = (r_dstep == D_RSQ) ? RSQ_MAX : (r_qneg ? NEG_MAX : POS_MAX);
    assign q_sat   = (r_ovf || q_round > q_max) ? q_max : q_round;
    assign q_field = r_qneg ? (FIELD_W'(0) - q_sat[FIELD_W-1:0]) : q_sat[FIELD_W-1:0];

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_FINISH) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        {r_n, r_sx, r_sy, r_sxy, r_sxx, r_syy} <= i_job_data;
                        r_mstep <= M_N_SXX;
                        r_state <= S_MUL_LOAD;
                    end
                end
                S_MUL_LOAD: begin
                    r_ma    <= WW'(a_mag[MW-1:0]);
                    r_mb    <= b_mag[MW-1:0];
                    r_mp    <= '0;
                    r_psign <= a_neg ^ b_neg;
                    r_cnt   <= CTW'(MW - 1);
                    r_state <= S_MUL_RUN;
                end
                S_MUL_RUN: begin
                    if (r_mb[0]) begin
                        r_mp <= r_mp + r_ma;
                    end
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                    r_cnt <= r_cnt - CTW'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_MUL_DONE;
                    end
                end
                S_MUL_DONE: begin
                    case (r_mstep)
                        M_SX_SX:  r_dx <= r_t1 - sprod;
                        M_SY_SY:  r_dy <= r_t1 - sprod;
                        M_SX_SY:  r_c  <= r_t1 - sprod;
                        M_SX_SXY: r_ni <= r_t1 - sprod;
                        M_C_C:    r_c2 <= r_mp;
                        M_DX_DY:  r_d2 <= r_mp;
                        default:  r_t1 <= sprod;
                    endcase
                    if (r_mstep == M_DX_DY) begin
                        r_dstep <= D_SLOPE;
                        r_state <= S_DIV_LOAD;
                    end else begin
                        r_mstep <= r_mstep + 4'd1;
                        r_state <= S_MUL_LOAD;
                    end
                end
                S_DIV_LOAD: begin
                    if (x_flat) begin
                        r_slope  <= '0;
                        r_icpt   <= '0;
                        r_rsq    <= '0;
                        r_status <= ST_XFLAT;
                        r_state  <= S_FINISH;
                    end else if (r_dstep == D_RSQ && y_flat) begin
                        r_rsq    <= '0;
                        r_status <= ST_YFLAT;
                        r_state  <= S_FINISH;
                    end else begin
                        r_den   <= d_den;
                        r_rem   <= d_num >> QSH;
                        r_dq    <= {d_num[QSH-1:0], {FRAC_SHIFT{1'b0}}};
                        r_ovf   <= (d_num >> QSH) >= d_den;
                        r_qneg  <= d_neg;
                        r_cnt   <= CTW'(QBITS - 1);
                        r_state <= ((d_num >> QSH) >= d_den) ? S_DIV_DONE : S_DIV_RUN;
                    end
                end
                S_DIV_RUN: begin
                    r_rem <= ge ? WW'(rs - {1'b0, r_den}) : rs[WW-1:0];
                    r_dq  <= {r_dq[QBITS-2:0], ge};
                    r_cnt <= r_cnt - CTW'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_DIV_DONE;
                    end
                end
                S_DIV_DONE: begin
                    case (r_dstep)
                        D_SLOPE: r_slope <= q_field;
                        D_ICPT:  r_icpt  <= q_field;
                        default: r_rsq   <= q_sat[RSQ_W-1:0];
                    endcase
                    if (r_dstep == D_RSQ) begin
                        r_status <= ST_OK;
                        r_state  <= S_FINISH;
                    end else begin
                        r_dstep <= r_dstep + 2'd1;
                        r_state <= S_DIV_LOAD;
                    end
                end
                S_FINISH: begin
                    if (!o_valid || i_ready) begin
                        o_valid        <= 1'b1;
                        o_slope        <= r_slope;
                        o_intercept    <= r_icpt;
                        o_r_squared    <= r_rsq;
                        o_sample_count <= r_n;
                        o_fit_status   <= r_status;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_rsq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_r_squared <= RSQ_W'(17'h10000))
        else $error("r squared above one");

    a_xflat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fit_status == ST_XFLAT) |->
        (o_slope == '0 && o_intercept == '0 && o_r_squared == '0))
        else $error("flat x spread with nonzero result");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_job_pop)
        else $error("job taken while solver busy");

endmodule

// ----- src/linear_least_squares_fit_core.sv -----
// Top level of the least-squares line fit core with r squared.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  in       | i_valid / o_ready  | i_x_value, i_y_value, i_last_sample
//  out      | o_valid / i_ready  | o_slope, o_intercept, o_r_squared,
//           |                    | o_sample_count, o_fit_status
//
// Sample items are taken one per cycle; the sums update in the cycle of accept.
// A last item hands the sums to a two-entry queue; the solver then works
// through each fit with its bit-serial multiplier and divider, and takes the
// next job only when idle. Input stalls only while the queue is full.
// Reset is synchronous and clears the sums, the queue and the solver.
`timescale 1ns / 1ps
module linear_least_squares_fit_core #(
    parameter int MAX_SAMPLES = 65535,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_x_value,
    input  logic signed [SAMPLE_BITS-1:0] i_y_value,
    input  logic                          i_last_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [llsf_pkg::FIELD_W-1:0]  o_slope,
    output logic [llsf_pkg::FIELD_W-1:0]  o_intercept,
    output logic [llsf_pkg::RSQ_W-1:0]    o_r_squared,
    output logic [llsf_pkg::CNT_W-1:0]    o_sample_count,
    output llsf_pkg::t_status             o_fit_status
);
    import llsf_pkg::*;

    localparam int SW     = SAMPLE_BITS + 17;
    localparam int PW     = 2 * SAMPLE_BITS + 16;
    localparam int SNAP_W = CNT_W + 2 * SW + 3 * PW;

    logic              push_valid, push_ready, job_valid, job_pop;
    logic [SNAP_W-1:0] push_data, job_data;

    llsf_accum #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS),
        .SW(SW),
        .PW(PW),
        .SNAP_W(SNAP_W)
    ) u_accum (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_x_value(i_x_value),
        .i_y_value(i_y_value),
        .i_last_sample(i_last_sample),
        .o_push_valid(push_valid),
        .i_push_ready(push_ready),
        .o_push_data(push_data)
    );

    llsf_fifo #(
        .WIDTH(SNAP_W)
    ) u_fifo (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push_valid),
        .i_data(push_data),
        .o_can_push(push_ready),
        .o_valid(job_valid),
        .i_pop(job_pop),
        .o_data(job_data)
    );

    llsf_solver #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .SW(SW),
        .PW(PW),
        .SNAP_W(SNAP_W)
    ) u_solver (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_job_valid(job_valid),
        .o_job_pop(job_pop),
        .i_job_data(job_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_slope(o_slope),
        .o_intercept(o_intercept),
        .o_r_squared(o_r_squared),
        .o_sample_count(o_sample_count),
        .o_fit_status(o_fit_status)
    );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the least-squares line fit core.
`timescale 1ns / 1ps
module tb_top;
    import llsf_pkg::*;

    typedef struct {
        logic [FIELD_W-1:0] slope;
        logic [FIELD_W-1:0] intercept;
        logic [RSQ_W-1:0]   r_squared;
        logic [CNT_W-1:0]   sample_count;
        t_status            fit_status;
    } fit_t;

    class fit_scoreboard;
        localparam int SAMPLE_LIMIT = 65535;
        logic signed [63:0] cnt, sx, sy, sxy, sxx, syy;
        fit_t pending[$];
        int errors;

        function new();
            errors = 0;
            clear_sums();
        endfunction

        function void clear_sums();
            cnt = 0; sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0;
        endfunction

        function logic [63:0] round_div(logic [255:0] num, logic [255:0] den,
                                        logic [63:0] top);
            logic [255:0] q;
            logic [63:0] v;
            q = (num << 17) / den;
            if (q[255:64] != 0) return top;
            v = (q[63:0] >> 1) + q[0];
            return (v > top) ? top : v;
        endfunction

        function logic [FIELD_W-1:0] q16(logic signed [255:0] num, logic [255:0] den);
            logic [63:0] m;
            if (num < 0) begin
                m = round_div(-num, den, 64'h8000_0000_0000);
                return FIELD_W'(-m);
            end
            m = round_div(num, den, 64'h7FFF_FFFF_FFFF);
            return FIELD_W'(m);
        endfunction

        function void note(logic signed [15:0] x, logic signed [15:0] y, logic last);
            logic signed [255:0] n, a, b, c, d, e, f, dx, dy, cxy, ni;
            fit_t r;
            if (cnt < SAMPLE_LIMIT) begin
                cnt = cnt + 1;
                sx  = sx + x;
                sy  = sy + y;
                sxy = sxy + 64'(x) * 64'(y);
                sxx = sxx + 64'(x) * 64'(x);
                syy = syy + 64'(y) * 64'(y);
            end
            if (!last) return;
            n = cnt; a = sx; b = sy; c = sxy; d = sxx; e = syy;
            dx  = n * d - a * a;
            dy  = n * e - b * b;
            cxy = n * c - a * b;
            ni  = d * b - a * c;
            r.slope = 0; r.intercept = 0; r.r_squared = 0;
            r.sample_count = cnt[15:0];
            if (dx <= 0) begin
                r.fit_status = ST_XFLAT;
            end else begin
                r.slope = q16(cxy, dx);
                r.intercept = q16(ni, dx);
                if (dy <= 0) begin
                    r.fit_status = ST_YFLAT;
                end else begin
                    f = cxy * cxy;
                    r.r_squared = RSQ_W'(round_div(f, dx * dy, 64'd65536));
                    r.fit_status = ST_OK;
                end
            end
            pending.push_back(r);
            clear_sums();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(fit_t got);
            fit_t w;
            if (pending.size() == 0) begin
                report("result item with nothing expected");
                return;
            end
            w = pending.pop_front();
            if (got.slope !== w.slope)
                report($sformatf("slope %h, expected %h", got.slope, w.slope));
            if (got.intercept !== w.intercept)
                report($sformatf("intercept %h, expected %h", got.intercept, w.intercept));
            if (got.r_squared !== w.r_squared)
                report($sformatf("r_squared %h, expected %h", got.r_squared, w.r_squared));
            if (got.sample_count !== w.sample_count)
                report($sformatf("count %0d, expected %0d", got.sample_count,
                                 w.sample_count));
            if (got.fit_status !== w.fit_status)
                report($sformatf("status %0d, expected %0d", got.fit_status,
                                 w.fit_status));
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic signed [15:0] i_x_value = 0;
    logic signed [15:0] i_y_value = 0;
    logic i_last_sample = 0;
    logic o_valid;
    logic i_ready = 0;
    logic [FIELD_W-1:0] o_slope, o_intercept;
    logic [RSQ_W-1:0] o_r_squared;
    logic [CNT_W-1:0] o_sample_count;
    t_status o_fit_status;

    int tx_idle = 0;
    int rx_idle = 0;
    logic rx_hold = 0;
    fit_scoreboard sb = new();

    linear_least_squares_fit_core dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        fit_t got;
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note(i_x_value, i_y_value, i_last_sample);
            if (o_valid && i_ready) begin
                got.slope = o_slope;
                got.intercept = o_intercept;
                got.r_squared = o_r_squared;
                got.sample_count = o_sample_count;
                got.fit_status = o_fit_status;
                sb.check(got);
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold || !i_rst_n) i_ready <= 0;
        else i_ready <= ($urandom_range(99) >= rx_idle);
    end

    task send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
        while ($urandom_range(99) < tx_idle) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1;
        i_x_value = x;
        i_y_value = y;
        i_last_sample = last;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task send_set(int len);
        int kind, i;
        logic signed [15:0] x, y, base, gain;
        kind = $urandom_range(9);
        base = 16'($urandom);
        gain = $signed(16'($urandom_range(15))) - 16'sd7;
        for (i = 0; i < len; i++) begin
            x = 16'($urandom);
            y = 16'($urandom);
            case (kind)
                0: x = base;
                1: y = base;
                2: begin
                    x = $signed(16'($urandom_range(400))) - 16'sd200;
                    y = x * gain + base[7:0];
                end
                3: begin
                    x = $signed(16'($urandom_range(400))) - 16'sd200;
                    y = x * gain + $signed(16'($urandom_range(6))) - 16'sd3;
                end
                4: x = $signed(16'($urandom_range(3))) + base;
                default: ;
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    task random_phase(int items);
        int sent, len;
        sent = 0;
        while (sent < items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40) + 1 : $urandom_range(7) + 1;
            send_set(len);
            sent += len;
        end
    endtask

    task hold_receiver(int cycles);
        rx_hold = 1;
        repeat (cycles) @(negedge i_clk);
        rx_hold = 0;
    endtask

    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;

        tx_idle = 36; rx_idle = 70;
        send_pair(16'sh7FFF, 16'sh8000, 1);
        send_pair(-16'sd5, 16'sd3, 0);
        send_pair(-16'sd5, 16'sd9, 0);
        send_pair(-16'sd5, -16'sd1, 1);
        send_pair(16'sd1, 16'sd100, 0);
        send_pair(16'sd9, 16'sd100, 0);
        send_pair(-16'sd4, 16'sd100, 1);
        send_pair(16'sd0, 16'sd7, 0);
        send_pair(16'sd1, 16'sd10, 0);
        send_pair(16'sd2, 16'sd13, 1);
        send_pair(16'sh7FFE, 16'sh8000, 0);
        send_pair(16'sh7FFF, 16'sh7FFF, 1);
        send_pair(16'sh8000, 16'sh8000, 0);
        send_pair(16'sh7FFF, 16'sh7FFF, 0);
        send_pair(16'sh8000, 16'sh7FFF, 0);
        send_pair(16'sh7FFF, 16'sh8000, 1);
        send_pair(16'sd3, 16'sd2, 0);
        send_pair(16'sd4, 16'sd8, 0);
        send_pair(-16'sd7, 16'sd1, 0);
        send_pair(16'sd12, -16'sd6, 1);
        random_phase(180);

        tx_idle = 70; rx_idle = 36;
        random_phase(180);

        tx_idle = 0; rx_idle = 0;
        fork
            hold_receiver(6000);
        join_none
        random_phase(60);
        wait (!rx_hold);
        random_phase(200);

        wait (sb.pending.size() == 0);
        repeat (1500) @(negedge i_clk);
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
